// ===== rtl/sfwt_pkg.sv =====
// Shared types and codes for the sorted word frequency table.
package sfwt_pkg;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_FULL      = 3'd2,
        ST_REP_ENTRY = 3'd3,
        ST_REP_EMPTY = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REPORT = 1'b1
    } t_command;

    typedef struct packed {
        t_command    command;
        logic [63:0] word_key;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] entry_key;
        logic [15:0] entry_count;
        logic [5:0]  entry_index;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_REP_RD,
        S_REP_CMP,
        S_REP_END
    } t_state;

endpackage

// ===== rtl/sorted_word_frequency_table_top.sv =====
// Sorted word frequency table: top level with command sequencer.
//
// An add binary-searches the table, and a found key finishes as soon as a
// probe matches it. A new key takes the full search. Then every entry above
// its slot is moved up one slot at a time, each read and then written back,
// and then the key is written into its slot. A report reads every filled
// slot in turn and then gives its last result.
// busy drops in the cycle that the last result of a command is on o_result;
// each result appears on o_result for one cycle with o_valid high and cannot
// be held off.
module sorted_word_frequency_table_top
    import sfwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_valid,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = AW + 1;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int EW = 64 + COUNT_BITS;

    t_state                r_state, n_state;
    logic [FW-1:0]         r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [FW-1:0]         r_fill, n_fill, r_idx, n_idx;
    logic [63:0]           r_key, n_key;
    logic [15:0]           r_thr;
    logic                  r_pend, n_pend;
    t_out_item             r_pend_res, n_pend_res;
    logic                  r_valid, n_valid;
    t_out_item             r_res, n_res;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [EW-1:0]         wdata, rdata;
    logic [63:0]           rd_key;
    logic [COUNT_BITS-1:0] rd_cnt, inc_cnt;
    logic [FW-1:0]         mid, idx_m1;

    sfwt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_key  = rdata[EW-1:COUNT_BITS];
    assign rd_cnt  = rdata[COUNT_BITS-1:0];
    assign inc_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_m1  = r_idx - FW'(1);
    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_item.command == CMD_ADD) ? S_SRCH : S_REP_RD;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else if (r_fill == FW'(TABLE_DEPTH)) begin
                    n_state = S_IDLE;
                end else if (r_fill > r_lo) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_CMP: begin
                n_state = (rd_key == r_key) ? S_IDLE : S_SRCH;
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (idx_m1 > r_lo) ? S_SHIFT_RD : S_INS;
            S_INS:      n_state = S_IDLE;
            S_REP_RD:   n_state = (r_idx < r_fill) ? S_REP_CMP : S_REP_END;
            S_REP_CMP:  n_state = S_REP_RD;
            S_REP_END:  n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_key      = r_key;
        n_pend     = r_pend;
        n_pend_res = r_pend_res;
        n_valid    = 1'b0;
        n_res      = r_res;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = r_idx[AW-1:0];
        raddr      = r_idx[AW-1:0];
        wdata      = rdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key  = i_item.word_key;
                    n_lo   = '0;
                    n_hi   = r_fill;
                    n_idx  = '0;
                    n_pend = 1'b0;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    re    = 1'b1;
                    raddr = mid[AW-1:0];
                    n_mid = mid;
                end else if (r_fill == FW'(TABLE_DEPTH)) begin
                    n_valid = 1'b1;
                    n_res   = '{ST_FULL, r_key, 16'd0, 6'd0, 1'b1};
                end else begin
                    n_idx = r_fill;
                end
            end
            S_CMP: begin
                if (rd_key == r_key) begin
                    we      = 1'b1;
                    waddr   = r_mid[AW-1:0];
                    wdata   = {r_key, inc_cnt};
                    n_valid = 1'b1;
                    n_res   = '{ST_FOUND, r_key, 16'(inc_cnt), 6'(r_mid), 1'b1};
                end else if (rd_key < r_key) begin
                    n_lo = r_mid + FW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            S_SHIFT_RD: begin
                re    = 1'b1;
                raddr = idx_m1[AW-1:0];
            end
            S_SHIFT_WR: begin
                we    = 1'b1;
                n_idx = idx_m1;
            end
            S_INS: begin
                we      = 1'b1;
                waddr   = r_lo[AW-1:0];
                wdata   = {r_key, COUNT_BITS'(1)};
                n_fill  = r_fill + FW'(1);
                n_valid = 1'b1;
                n_res   = '{ST_INSERTED, r_key, 16'd1, 6'(r_lo), 1'b1};
            end
            S_REP_RD: begin
                re = (r_idx < r_fill);
            end
            S_REP_CMP: begin
                if (CW'(rd_cnt) > CW'(r_thr)) begin
                    n_valid    = r_pend;
                    n_res      = r_pend_res;
                    n_pend     = 1'b1;
                    n_pend_res = '{ST_REP_ENTRY, rd_key, 16'(rd_cnt), 6'(r_idx), 1'b0};
                end
                n_idx = r_idx + FW'(1);
            end
            S_REP_END: begin
                n_valid = 1'b1;
                if (r_pend) begin
                    n_res      = r_pend_res;
                    n_res.last = 1'b1;
                end else begin
                    n_res = '{ST_REP_EMPTY, 64'd0, 16'd0, 6'd0, 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_thr   <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_pend_res <= n_pend_res;
        r_res      <= n_res;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill level beyond table depth");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");
    a_ins_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_valid && r_res.status == ST_INSERTED
            |-> r_fill == $past(r_fill) + FW'(1))
        else $error("insert without fill increment");
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.status == ST_FULL |-> r_fill == FW'(TABLE_DEPTH))
        else $error("drop while table not full");
`endif
endmodule

// ===== rtl/sfwt_ram.sv =====
// Single-port-write, registered-read memory holding key and count per slot.
module sfwt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
